FILE: hdl/alu16_pkg.sv
`default_nettype none
package alu16_pkg;

  localparam int DATA_W          = 16;
  localparam int CMD_W           = 4;
  localparam int DIV_STEPS       = 4;                 // quotient bits per divider stage
  localparam int DIV_STAGES      = DATA_W / DIV_STEPS;
  localparam int LATENCY         = DIV_STAGES + 2;    // front + divider + output register

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_MOD = 4'd4,
    CMD_AND = 4'd5,
    CMD_OR  = 4'd6,
    CMD_XOR = 4'd7,
    CMD_NOT = 4'd8,
    CMD_CMP = 4'd9
  } cmd_t;

  // Which source the output stage takes the result from
  typedef enum logic [1:0] {
    SEL_FAST,
    SEL_CMP,
    SEL_DIV,
    SEL_MOD
  } sel_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic              use_carry;
    logic              carry_in;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              flag_greater;
    logic              flag_lesser;
    logic              flag_equal;
    logic              flag_zero;
    logic              flag_carry;
    logic              flag_overflow;
    logic              flag_div_zero;
    logic              flag_negative;
  } out_beat_t;

  // Side data that rides along the divider stages
  typedef struct packed {
    sel_t      sel;
    logic      b_zero;
    out_beat_t fast;
  } side_t;

  // Restoring divider state
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] divisor;
  } div_state_t;

  typedef struct packed {
    logic       valid;
    side_t      side;
    div_state_t dv;
  } pipe_t;

endpackage
`default_nettype wire

FILE: hdl/alu16_front.sv
`default_nettype none
module alu16_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire alu16_pkg::in_beat_t in_data,
  output alu16_pkg::pipe_t        pipe_out
);
  import alu16_pkg::*;

  logic [DATA_W:0]     sum;
  logic [2*DATA_W-1:0] prod;
  side_t               side;
  logic                valid_r;
  side_t               side_r;
  div_state_t          dv_r;

  assign sum  = {1'b0, in_data.operand_a} + {1'b0, in_data.operand_b}
              + {{DATA_W{1'b0}}, in_data.use_carry & in_data.carry_in};
  assign prod = {{DATA_W{1'b0}}, in_data.operand_a} * {{DATA_W{1'b0}}, in_data.operand_b};

  // Fast operations and compare; divide and modulo only select their result source
  always_comb begin
    side             = '0;
    side.sel         = SEL_FAST;
    side.b_zero      = (in_data.operand_b == '0);
    side.fast.result = in_data.operand_a;
    unique case (in_data.command)
      CMD_ADD: begin
        side.fast.result     = sum[DATA_W-1:0];
        side.fast.flag_carry = sum[DATA_W];
      end
      CMD_SUB: begin
        side.fast.result        = in_data.operand_a - in_data.operand_b;
        side.fast.flag_negative = (in_data.operand_a < in_data.operand_b);
      end
      CMD_MUL: begin
        side.fast.result        = prod[DATA_W-1:0];
        side.fast.flag_overflow = |prod[2*DATA_W-1:DATA_W];
      end
      CMD_DIV: side.sel = SEL_DIV;
      CMD_MOD: side.sel = SEL_MOD;
      CMD_AND: side.fast.result = in_data.operand_a & in_data.operand_b;
      CMD_OR:  side.fast.result = in_data.operand_a | in_data.operand_b;
      CMD_XOR: side.fast.result = in_data.operand_a ^ in_data.operand_b;
      CMD_NOT: side.fast.result = ~in_data.operand_a;
      CMD_CMP: begin
        side.sel               = SEL_CMP;
        side.fast.flag_greater = (in_data.operand_a > in_data.operand_b);
        side.fast.flag_lesser  = (in_data.operand_a < in_data.operand_b);
        side.fast.flag_equal   = (in_data.operand_a == in_data.operand_b);
      end
      default: side.fast.result = in_data.operand_a;
    endcase
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  // Payload, divider seeded with the dividend
  always_ff @(posedge clk) begin
    side_r     <= side;
    dv_r.rem   <= '0;
    dv_r.quo   <= in_data.operand_a;
    dv_r.divisor <= in_data.operand_b;
  end

  assign pipe_out.valid = valid_r;
  assign pipe_out.side  = side_r;
  assign pipe_out.dv    = dv_r;

endmodule
`default_nettype wire

FILE: hdl/alu16_div_stage.sv
`default_nettype none
module alu16_div_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire alu16_pkg::pipe_t pipe_in,
  output alu16_pkg::pipe_t      pipe_out
);
  import alu16_pkg::*;

  div_state_t     dv;
  logic [DATA_W:0] trial;
  logic            valid_r;
  side_t           side_r;
  div_state_t      dv_r;

  // DIV_STEPS (four) restoring-division steps, one quotient bit each
  always_comb begin
    dv    = pipe_in.dv;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {dv.rem, dv.quo[DATA_W-1]};
      if (trial >= {1'b0, dv.divisor}) begin
        trial  = trial - {1'b0, dv.divisor};
        dv.quo = {dv.quo[DATA_W-2:0], 1'b1};
      end else begin
        dv.quo = {dv.quo[DATA_W-2:0], 1'b0};
      end
      dv.rem = trial[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= pipe_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r <= pipe_in.side;
    dv_r   <= dv;
  end

  assign pipe_out.valid = valid_r;
  assign pipe_out.side  = side_r;
  assign pipe_out.dv    = dv_r;

endmodule
`default_nettype wire

FILE: hdl/alu_16bit_with_flags_top.sv
`default_nettype none
// 16-bit unsigned ALU with flags.
//
// Input: raise start with an operation beat on in_data; the beat is taken
// at the clock edge where start is high and busy is low. busy stays low, so
// a new beat may be issued on every cycle.
// Output: each beat gives exactly one result on out_data, shown for one
// cycle with out_valid high. The receiver cannot hold results off.
// Path: the beat passes the front stage, four divider stages of four
// quotient bits each, and the output register; out_valid rises once the
// result is in the output register. Every operation takes the same path,
// so results leave in order. Throughput: one beat per cycle, set by the
// pipelined restoring divider.
// Reset (rst_n low, synchronous) drops all beats in flight; out_valid is
// low on the cycle after reset.
module alu_16bit_with_flags_top (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire alu16_pkg::in_beat_t  in_data,
  output logic                      out_valid,
  output alu16_pkg::out_beat_t      out_data
);
  import alu16_pkg::*;

  pipe_t     stage [DIV_STAGES+1];
  out_beat_t res_nxt;
  out_beat_t out_data_r;
  logic      out_valid_r;
  side_t     tail;

  assign busy = 1'b0;

  alu16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (start & ~busy),
    .in_data  (in_data),
    .pipe_out (stage[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    alu16_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .pipe_in  (stage[g]),
      .pipe_out (stage[g+1])
    );
  end

  assign tail = stage[DIV_STAGES].side;

  // Pick the result source and finish the flags
  always_comb begin
    res_nxt = tail.fast;
    case (tail.sel)
      SEL_DIV: begin
        res_nxt.result        = tail.b_zero ? '0 : stage[DIV_STAGES].dv.quo;
        res_nxt.flag_div_zero = tail.b_zero;
      end
      SEL_MOD: begin
        res_nxt.result        = tail.b_zero ? '0 : stage[DIV_STAGES].dv.rem;
        res_nxt.flag_div_zero = tail.b_zero;
      end
      default: res_nxt.result = tail.fast.result;
    endcase
    res_nxt.flag_zero = (tail.sel != SEL_CMP) && (res_nxt.result == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stage[DIV_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted beat comes out with out_valid once it has passed the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
     && $past(rst_n, 5) && $past(rst_n, LATENCY))
    |-> (out_valid == $past(start & ~busy, LATENCY)))
    else $error("result strobe does not match accepted beat");

  // Division by zero forces a zero result
  a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.flag_div_zero)
    |-> (out_data.result == '0 && out_data.flag_zero))
    else $error("div-by-zero result not cleared");

  // Compare flags are exclusive and compare never sets zero, carry or div-by-zero
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.flag_greater || out_data.flag_lesser || out_data.flag_equal))
    |-> ($onehot({out_data.flag_greater, out_data.flag_lesser, out_data.flag_equal})
         && !out_data.flag_zero && !out_data.flag_carry && !out_data.flag_div_zero))
    else $error("compare flags inconsistent");

endmodule
`default_nettype wire
